/* hdl/iffc_pkg.sv */
package iffc_pkg;

    localparam int HEADER_BYTES   = 21;
    localparam int TRAILER_BYTES  = 4;
    localparam int HDR_CRC_SPAN   = 17;
    localparam int COUNT_BITS_DEF = 32;
    localparam int PLEN_BITS      = 32;
    localparam int END_BITS       = PLEN_BITS + 1;
    localparam int OUT_BITS       = 88;
    localparam int APB_ADDR_BITS  = 4;
    localparam int APB_DATA_BITS  = 32;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
    localparam logic [15:0] DIM_MAX  = 16'd2000;
    localparam logic [7:0]  ROT_MAX  = 8'd3;
    localparam logic [7:0]  COLOR_MAX = 8'd1;

    typedef enum logic [1:0] {
        REG_MAGIC     = 2'd0,
        REG_VERSION   = 2'd1,
        REG_PAYLOAD   = 2'd2,
        REG_CHECK_CRC = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        STATUS_OK          = 3'd0,
        STATUS_TRUNCATED   = 3'd1,
        STATUS_HEADER_BAD  = 3'd2,
        STATUS_DIMS_BAD    = 3'd3,
        STATUS_SIZE_BAD    = 3'd4,
        STATUS_CORRUPTED   = 3'd5
    } status_t;

    typedef struct packed {
        logic [31:0] magic;
        logic [7:0]  version;
        logic [21:0] payload_bytes;
        logic        check_crc;
    } cfg_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

/* hdl/iffc_cfg_regs.sv */
module iffc_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [iffc_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [iffc_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [iffc_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output iffc_pkg::cfg_t                      cfg
);

    iffc_pkg::cfg_t     cfg_reg;
    iffc_pkg::cfg_t     cfg_next;
    iffc_pkg::reg_index_t idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign idx    = iffc_pkg::reg_index_t'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite & pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                iffc_pkg::REG_MAGIC:     cfg_next.magic         = pwdata;
                iffc_pkg::REG_VERSION:   cfg_next.version       = pwdata[7:0];
                iffc_pkg::REG_PAYLOAD:   cfg_next.payload_bytes = pwdata[21:0];
                iffc_pkg::REG_CHECK_CRC: cfg_next.check_crc     = pwdata[0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic         <= 32'd0;
            cfg_reg.version       <= 8'd0;
            cfg_reg.payload_bytes <= 22'd0;
            cfg_reg.check_crc     <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            iffc_pkg::REG_MAGIC:     prdata = cfg_reg.magic;
            iffc_pkg::REG_VERSION:   prdata = {24'd0, cfg_reg.version};
            iffc_pkg::REG_PAYLOAD:   prdata = {10'd0, cfg_reg.payload_bytes};
            iffc_pkg::REG_CHECK_CRC: prdata = {31'd0, cfg_reg.check_crc};
            default:                 prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/image_file_frame_checker.sv */
// Image file frame checker.
// Input stream (s_*): one file byte per transaction in s_tdata, s_tlast high
// on the final byte. Output stream (m_*): one status transaction per file,
// produced by the transaction that carries s_tlast.
// Configuration: APB port, registers at byte addresses 0x0 magic, 0x4
// version, 0x8 required payload length, 0xC payload CRC enable (reset 1).
// Write registers only while no file is in flight.
// Throughput: one byte per cycle while s_tready is high; header capture and
// the byte-wide CRC-32 update sit between the state registers.
// Latency: the status appears on m_tvalid the cycle after the last byte is
// accepted and is held in the output register until m_tready.
// Stall: while a status waits, non-last bytes of the next file keep flowing;
// only a last byte is held off (s_tready low) until the output slot frees.
// Reset (rst_n, async, active low) clears the byte counter, CRC and header
// fields and empties the output register; configuration returns to reset.
// After each last byte the file state clears and the next byte starts a new
// file. The byte counter saturates at 2**COUNT_BITS-1.
module image_file_frame_checker #(
    parameter int COUNT_BITS = iffc_pkg::COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,    // [7:0] data_byte
    input  logic                                s_tlast,    // last_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [2:0] status, [18:3] image_width, [34:19] image_height,
    // [42:35] rotation_code, [50:43] color_mode_code, [82:51] payload_length,
    // [83] version_warning, [87:84] zero
    output logic [iffc_pkg::OUT_BITS-1:0]       m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [iffc_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [iffc_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [iffc_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);

    localparam int EB = iffc_pkg::END_BITS;

    iffc_pkg::cfg_t cfg;

    iffc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [COUNT_BITS-1:0] offset_reg, offset_next;
    logic [31:0] run_crc_reg, run_crc_next, run_crc_upd;
    logic [31:0] hdr_crc_calc_reg, hdr_crc_calc_next, hdr_crc_calc_upd;
    logic [31:0] pay_crc_calc_reg, pay_crc_calc_next, pay_crc_calc_upd;
    logic [31:0] magic_reg, magic_next, magic_upd;
    logic [7:0]  version_reg, version_next, version_upd;
    logic [15:0] hdr_len_reg, hdr_len_next, hdr_len_upd;
    logic [15:0] width_reg, width_next, width_upd;
    logic [15:0] height_reg, height_next, height_upd;
    logic [7:0]  rot_reg, rot_next, rot_upd;
    logic [7:0]  color_reg, color_next, color_upd;
    logic [31:0] plen_reg, plen_next, plen_upd;
    logic [31:0] hdr_crc_fld_reg, hdr_crc_fld_next, hdr_crc_fld_upd;
    logic [31:0] trl_crc_reg, trl_crc_next, trl_crc_upd;

    logic [31:0]   prod_reg;
    logic [EB-1:0] pay_end_reg;

    logic                      out_valid_reg;
    logic [iffc_pkg::OUT_BITS-1:0] out_data_reg, result;

    logic          byte_accept;
    logic          sat;
    logic [EB-1:0] off_ext;
    logic          in_header;
    logic [4:0]    k;
    logic [EB:0]   diff;
    logic          before_end;
    logic [EB-1:0] past;
    logic          in_payload;
    logic          in_trailer;
    logic [31:0]   crc_new;
    logic          magic_ok;
    logic          hdr_bad;
    iffc_pkg::status_t status;

    assign s_tready    = !s_tlast || !out_valid_reg || m_tready;
    assign byte_accept = s_tvalid & s_tready;

    assign sat        = &offset_reg;
    assign off_ext    = EB'(offset_reg);
    assign in_header  = off_ext < EB'(iffc_pkg::HEADER_BYTES);
    assign k          = offset_reg[4:0];
    assign diff       = {1'b0, off_ext} - {1'b0, pay_end_reg};
    assign before_end = diff[EB];
    assign past       = diff[EB-1:0];
    assign in_payload = !in_header && before_end;
    assign in_trailer = !in_header && !before_end && (past[EB-1:2] == '0);
    assign crc_new    = iffc_pkg::crc_byte(run_crc_reg, s_tdata);

    // capture of the current byte
    always_comb
    begin
        run_crc_upd      = run_crc_reg;
        hdr_crc_calc_upd = hdr_crc_calc_reg;
        pay_crc_calc_upd = pay_crc_calc_reg;
        magic_upd        = magic_reg;
        version_upd      = version_reg;
        hdr_len_upd      = hdr_len_reg;
        width_upd        = width_reg;
        height_upd       = height_reg;
        rot_upd          = rot_reg;
        color_upd        = color_reg;
        plen_upd         = plen_reg;
        hdr_crc_fld_upd  = hdr_crc_fld_reg;
        trl_crc_upd      = trl_crc_reg;
        if (in_header)
        begin
            case (k)
                5'd0:    magic_upd[7:0]        = s_tdata;
                5'd1:    magic_upd[15:8]       = s_tdata;
                5'd2:    magic_upd[23:16]      = s_tdata;
                5'd3:    magic_upd[31:24]      = s_tdata;
                5'd4:    version_upd           = s_tdata;
                5'd5:    hdr_len_upd[7:0]      = s_tdata;
                5'd6:    hdr_len_upd[15:8]     = s_tdata;
                5'd7:    width_upd[7:0]        = s_tdata;
                5'd8:    width_upd[15:8]       = s_tdata;
                5'd9:    height_upd[7:0]       = s_tdata;
                5'd10:   height_upd[15:8]      = s_tdata;
                5'd11:   rot_upd               = s_tdata;
                5'd12:   color_upd             = s_tdata;
                5'd13:   plen_upd[7:0]         = s_tdata;
                5'd14:   plen_upd[15:8]        = s_tdata;
                5'd15:   plen_upd[23:16]       = s_tdata;
                5'd16:   plen_upd[31:24]       = s_tdata;
                5'd17:   hdr_crc_fld_upd[7:0]  = s_tdata;
                5'd18:   hdr_crc_fld_upd[15:8] = s_tdata;
                5'd19:   hdr_crc_fld_upd[23:16] = s_tdata;
                default: hdr_crc_fld_upd[31:24] = s_tdata;
            endcase
            if (k < 5'(iffc_pkg::HDR_CRC_SPAN))
            begin
                run_crc_upd = crc_new;
                if (k == 5'(iffc_pkg::HDR_CRC_SPAN - 1))
                begin
                    hdr_crc_calc_upd = ~crc_new;
                    run_crc_upd      = iffc_pkg::CRC_ONES;
                end
            end
        end
        else if (in_payload)
        begin
            run_crc_upd      = crc_new;
            pay_crc_calc_upd = ~crc_new;
        end
        else if (in_trailer)
        begin
            case (past[1:0])
                2'd0:    trl_crc_upd[7:0]   = s_tdata;
                2'd1:    trl_crc_upd[15:8]  = s_tdata;
                2'd2:    trl_crc_upd[23:16] = s_tdata;
                default: trl_crc_upd[31:24] = s_tdata;
            endcase
        end
    end

    // verdict at the last byte
    assign magic_ok = magic_upd == cfg.magic;
    assign hdr_bad  = !magic_ok
                   || hdr_len_upd != 16'(iffc_pkg::HEADER_BYTES)
                   || rot_upd > iffc_pkg::ROT_MAX
                   || color_upd > iffc_pkg::COLOR_MAX
                   || width_upd == 16'd0 || height_upd == 16'd0
                   || width_upd > iffc_pkg::DIM_MAX || height_upd > iffc_pkg::DIM_MAX
                   || hdr_crc_calc_upd != hdr_crc_fld_upd
                   || before_end || past < EB'(3);

    always_comb
    begin
        if (off_ext < EB'(iffc_pkg::HEADER_BYTES + iffc_pkg::TRAILER_BYTES - 1))
            status = iffc_pkg::STATUS_TRUNCATED;
        else if (hdr_bad)
            status = iffc_pkg::STATUS_HEADER_BAD;
        else if (plen_upd != prod_reg || plen_upd != {10'd0, cfg.payload_bytes})
            status = iffc_pkg::STATUS_DIMS_BAD;
        else if (sat || past != EB'(3))
            status = iffc_pkg::STATUS_SIZE_BAD;
        else if (cfg.check_crc && pay_crc_calc_upd != trl_crc_upd)
            status = iffc_pkg::STATUS_CORRUPTED;
        else
            status = iffc_pkg::STATUS_OK;

        if (status == iffc_pkg::STATUS_TRUNCATED)
            result = {85'd0, status};
        else
            result = {4'd0, magic_ok && (version_upd != cfg.version), plen_upd,
                      color_upd, rot_upd, height_upd, width_upd, status};
    end

    always_comb
    begin
        offset_next       = offset_reg;
        run_crc_next      = run_crc_reg;
        hdr_crc_calc_next = hdr_crc_calc_reg;
        pay_crc_calc_next = pay_crc_calc_reg;
        magic_next        = magic_reg;
        version_next      = version_reg;
        hdr_len_next      = hdr_len_reg;
        width_next        = width_reg;
        height_next       = height_reg;
        rot_next          = rot_reg;
        color_next        = color_reg;
        plen_next         = plen_reg;
        hdr_crc_fld_next  = hdr_crc_fld_reg;
        trl_crc_next      = trl_crc_reg;
        if (byte_accept)
        begin
            if (s_tlast)
            begin
                offset_next       = '0;
                run_crc_next      = iffc_pkg::CRC_ONES;
                hdr_crc_calc_next = '0;
                pay_crc_calc_next = '0;
                magic_next        = '0;
                version_next      = '0;
                hdr_len_next      = '0;
                width_next        = '0;
                height_next       = '0;
                rot_next          = '0;
                color_next        = '0;
                plen_next         = '0;
                hdr_crc_fld_next  = '0;
                trl_crc_next      = '0;
            end
            else
            begin
                offset_next       = sat ? offset_reg : offset_reg + 1'b1;
                run_crc_next      = run_crc_upd;
                hdr_crc_calc_next = hdr_crc_calc_upd;
                pay_crc_calc_next = pay_crc_calc_upd;
                magic_next        = magic_upd;
                version_next      = version_upd;
                hdr_len_next      = hdr_len_upd;
                width_next        = width_upd;
                height_next       = height_upd;
                rot_next          = rot_upd;
                color_next        = color_upd;
                plen_next         = plen_upd;
                hdr_crc_fld_next  = hdr_crc_fld_upd;
                trl_crc_next      = trl_crc_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg       <= '0;
            run_crc_reg      <= iffc_pkg::CRC_ONES;
            hdr_crc_calc_reg <= '0;
            pay_crc_calc_reg <= '0;
            magic_reg        <= '0;
            version_reg      <= '0;
            hdr_len_reg      <= '0;
            width_reg        <= '0;
            height_reg       <= '0;
            rot_reg          <= '0;
            color_reg        <= '0;
            plen_reg         <= '0;
            hdr_crc_fld_reg  <= '0;
            trl_crc_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            offset_reg       <= offset_next;
            run_crc_reg      <= run_crc_next;
            hdr_crc_calc_reg <= hdr_crc_calc_next;
            pay_crc_calc_reg <= pay_crc_calc_next;
            magic_reg        <= magic_next;
            version_reg      <= version_next;
            hdr_len_reg      <= hdr_len_next;
            width_reg        <= width_next;
            height_reg       <= height_next;
            rot_reg          <= rot_next;
            color_reg        <= color_next;
            plen_reg         <= plen_next;
            hdr_crc_fld_reg  <= hdr_crc_fld_next;
            trl_crc_reg      <= trl_crc_next;
            if (byte_accept && s_tlast)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // header-derived terms, settled long before the payload starts, and the result capture at the last byte
    always_ff @(posedge clk)
    begin
        prod_reg    <= 32'(width_reg) * 32'(height_reg);
        pay_end_reg <= EB'(iffc_pkg::HEADER_BYTES) + {1'b0, plen_reg};
        if (byte_accept && s_tlast)
            out_data_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= iffc_pkg::STATUS_CORRUPTED)
        else $error("status code out of range");

    a_trunc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2:0] == iffc_pkg::STATUS_TRUNCATED) |-> m_tdata[87:3] == '0)
        else $error("truncated result carries header fields");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_accept && s_tlast) |=> (offset_reg == '0 && run_crc_reg == iffc_pkg::CRC_ONES))
        else $error("file state not cleared after last byte");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && s_tlast) |-> !s_tready)
        else $error("last byte accepted while result pending");

endmodule
